// ===== rtl/core/ppt_pkg.sv =====
// Shared types and constants for the projective point transform.
package ppt_pkg;

    localparam int COORD_W   = 32;
    localparam int PROD_W    = 64;
    localparam int SUM_W     = 65;
    localparam int MAG_W     = 64;
    localparam int DIV_STEPS = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int MIN_DIV_W = 31;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_DIV   = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW0_XY       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW0_T_ROW1_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1_Y_T      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2_XY       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2_T        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIV       = 3'd5;

    typedef struct packed {
        logic signed [COORD_W-1:0] h00;
        logic signed [COORD_W-1:0] h01;
        logic signed [COORD_W-1:0] h02;
        logic signed [COORD_W-1:0] h10;
        logic signed [COORD_W-1:0] h11;
        logic signed [COORD_W-1:0] h12;
        logic signed [COORD_W-1:0] h20;
        logic signed [COORD_W-1:0] h21;
        logic signed [COORD_W-1:0] h22;
    } coef_t;

    // Flags that travel alongside the division.
    typedef struct packed {
        logic div_err;
        logic ovf_x;
        logic ovf_y;
        logic neg_x;
        logic neg_y;
    } side_t;

endpackage

// ===== rtl/core/ppt_rows.sv =====
// Products and row sums of the homography: two register stages.
module ppt_rows
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_vld,
    input  logic signed [ppt_pkg::COORD_W-1:0]   x,
    input  logic signed [ppt_pkg::COORD_W-1:0]   y,
    input  ppt_pkg::coef_t                       coef,
    output logic                                 vld,
    output logic signed [ppt_pkg::SUM_W-1:0]     w,
    output logic signed [ppt_pkg::SUM_W-1:0]     nx,
    output logic signed [ppt_pkg::SUM_W-1:0]     ny
);

    logic                                 v1_reg;
    logic                                 v2_reg;
    logic signed [ppt_pkg::PROD_W-1:0]    p00_reg, p01_reg, p10_reg;
    logic signed [ppt_pkg::PROD_W-1:0]    p11_reg, p20_reg, p21_reg;
    logic signed [ppt_pkg::PROD_W-1:0]    p00_next, p01_next, p10_next;
    logic signed [ppt_pkg::PROD_W-1:0]    p11_next, p20_next, p21_next;
    logic signed [ppt_pkg::SUM_W-1:0]     w_reg, nx_reg, ny_reg;
    logic signed [ppt_pkg::SUM_W-1:0]     w_next, nx_next, ny_next;

    always_comb
    begin
        p00_next = ppt_pkg::PROD_W'(coef.h00) * ppt_pkg::PROD_W'(x);
        p01_next = ppt_pkg::PROD_W'(coef.h01) * ppt_pkg::PROD_W'(y);
        p10_next = ppt_pkg::PROD_W'(coef.h10) * ppt_pkg::PROD_W'(x);
        p11_next = ppt_pkg::PROD_W'(coef.h11) * ppt_pkg::PROD_W'(y);
        p20_next = ppt_pkg::PROD_W'(coef.h20) * ppt_pkg::PROD_W'(x);
        p21_next = ppt_pkg::PROD_W'(coef.h21) * ppt_pkg::PROD_W'(y);
    end

    // The constant terms are aligned to the fraction point of the products.
    always_comb
    begin
        w_next  = ppt_pkg::SUM_W'(p20_reg) + ppt_pkg::SUM_W'(p21_reg)
                + (ppt_pkg::SUM_W'(coef.h22) <<< 30);
        nx_next = ppt_pkg::SUM_W'(p00_reg) + ppt_pkg::SUM_W'(p01_reg)
                + (ppt_pkg::SUM_W'(coef.h02) <<< 16);
        ny_next = ppt_pkg::SUM_W'(p10_reg) + ppt_pkg::SUM_W'(p11_reg)
                + (ppt_pkg::SUM_W'(coef.h12) <<< 16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg <= p00_next;
            p01_reg <= p01_next;
            p10_reg <= p10_next;
            p11_reg <= p11_next;
            p20_reg <= p20_next;
            p21_reg <= p21_next;
            w_reg   <= w_next;
            nx_reg  <= nx_next;
            ny_reg  <= ny_next;
        end
    end

    assign vld = v2_reg;
    assign w   = w_reg;
    assign nx  = nx_reg;
    assign ny  = ny_reg;

endmodule

// ===== rtl/core/ppt_prep.sv =====
// Magnitudes, divisor check, overflow pre-check and divider set-up: two stages.
module ppt_prep
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_vld,
    input  logic signed [ppt_pkg::SUM_W-1:0]     w,
    input  logic signed [ppt_pkg::SUM_W-1:0]     nx,
    input  logic signed [ppt_pkg::SUM_W-1:0]     ny,
    input  logic [ppt_pkg::MIN_DIV_W-1:0]        min_div,
    output logic                                 vld,
    output logic [ppt_pkg::MAG_W-1:0]            d,
    output logic [ppt_pkg::MAG_W-1:0]            rx,
    output logic [ppt_pkg::MAG_W-1:0]            ry,
    output logic [1:0]                           lx,
    output logic [1:0]                           ly,
    output ppt_pkg::side_t                       side
);

    logic                          v3_reg, v4_reg;
    logic [ppt_pkg::MAG_W-1:0]     wm_reg, mx_reg, my_reg;
    logic [ppt_pkg::MAG_W-1:0]     wm_next, mx_next, my_next;
    logic                          wneg_reg, xneg_reg, yneg_reg;
    logic [ppt_pkg::MAG_W-1:0]     d_reg, rx_reg, ry_reg;
    logic [1:0]                    lx_reg, ly_reg;
    ppt_pkg::side_t                side_reg, side_next;
    logic [ppt_pkg::MAG_W-1:0]     min_scaled;

    always_comb
    begin
        wm_next = w[ppt_pkg::SUM_W-1]  ? ppt_pkg::MAG_W'(-w)  : ppt_pkg::MAG_W'(w);
        mx_next = nx[ppt_pkg::SUM_W-1] ? ppt_pkg::MAG_W'(-nx) : ppt_pkg::MAG_W'(nx);
        my_next = ny[ppt_pkg::SUM_W-1] ? ppt_pkg::MAG_W'(-ny) : ppt_pkg::MAG_W'(ny);
    end

    // The limit is compared at the 46 fraction bits of w.
    assign min_scaled = {3'b000, min_div, 30'b0};

    // A quotient of 2^32 or more shows up as the numerator reaching four times w.
    always_comb
    begin
        side_next.div_err = (wm_reg == '0) || (wm_reg < min_scaled);
        side_next.ovf_x   = {2'b00, mx_reg} >= {wm_reg, 2'b00};
        side_next.ovf_y   = {2'b00, my_reg} >= {wm_reg, 2'b00};
        side_next.neg_x   = xneg_reg ^ wneg_reg;
        side_next.neg_y   = yneg_reg ^ wneg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= in_vld;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wm_reg   <= wm_next;
            mx_reg   <= mx_next;
            my_reg   <= my_next;
            wneg_reg <= w[ppt_pkg::SUM_W-1];
            xneg_reg <= nx[ppt_pkg::SUM_W-1];
            yneg_reg <= ny[ppt_pkg::SUM_W-1];
            d_reg    <= wm_reg;
            rx_reg   <= {2'b00, mx_reg[ppt_pkg::MAG_W-1:2]};
            ry_reg   <= {2'b00, my_reg[ppt_pkg::MAG_W-1:2]};
            lx_reg   <= mx_reg[1:0];
            ly_reg   <= my_reg[1:0];
            side_reg <= side_next;
        end
    end

    assign vld  = v4_reg;
    assign d    = d_reg;
    assign rx   = rx_reg;
    assign ry   = ry_reg;
    assign lx   = lx_reg;
    assign ly   = ly_reg;
    assign side = side_reg;

endmodule

// ===== rtl/core/ppt_div.sv =====
// Restoring divider for both quotients, one quotient bit per pipeline stage.
module ppt_div
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_vld,
    input  logic [ppt_pkg::MAG_W-1:0]            d,
    input  logic [ppt_pkg::MAG_W-1:0]            rx,
    input  logic [ppt_pkg::MAG_W-1:0]            ry,
    input  logic [1:0]                           lx,
    input  logic [1:0]                           ly,
    input  ppt_pkg::side_t                       side_in,
    output logic                                 vld,
    output logic [ppt_pkg::COORD_W-1:0]          qx,
    output logic [ppt_pkg::COORD_W-1:0]          qy,
    output ppt_pkg::side_t                       side_out
);

    localparam int N = ppt_pkg::DIV_STEPS;

    logic                          v_reg    [N];
    logic [ppt_pkg::MAG_W-1:0]     d_reg    [N];
    logic [ppt_pkg::MAG_W-1:0]     rx_reg   [N];
    logic [ppt_pkg::MAG_W-1:0]     ry_reg   [N];
    logic [1:0]                    lx_reg   [N];
    logic [1:0]                    ly_reg   [N];
    logic [ppt_pkg::COORD_W-1:0]   qx_reg   [N];
    logic [ppt_pkg::COORD_W-1:0]   qy_reg   [N];
    ppt_pkg::side_t                side_reg [N];

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic                          v_prev;
        logic [ppt_pkg::MAG_W-1:0]     d_prev, rx_prev, ry_prev;
        logic [1:0]                    lx_prev, ly_prev;
        logic [ppt_pkg::COORD_W-1:0]   qx_prev, qy_prev;
        ppt_pkg::side_t                side_prev;
        logic                          bx, by;
        logic [ppt_pkg::MAG_W:0]       tx, ty;
        logic [ppt_pkg::MAG_W+1:0]     dx, dy;
        logic [ppt_pkg::MAG_W-1:0]     rx_next, ry_next;
        logic [ppt_pkg::COORD_W-1:0]   qx_next, qy_next;

        if (k == 0)
        begin : g_first
            assign v_prev    = in_vld;
            assign d_prev    = d;
            assign rx_prev   = rx;
            assign ry_prev   = ry;
            assign lx_prev   = lx;
            assign ly_prev   = ly;
            assign qx_prev   = '0;
            assign qy_prev   = '0;
            assign side_prev = side_in;
        end
        else
        begin : g_rest
            assign v_prev    = v_reg[k-1];
            assign d_prev    = d_reg[k-1];
            assign rx_prev   = rx_reg[k-1];
            assign ry_prev   = ry_reg[k-1];
            assign lx_prev   = lx_reg[k-1];
            assign ly_prev   = ly_reg[k-1];
            assign qx_prev   = qx_reg[k-1];
            assign qy_prev   = qy_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        // Only the first two steps bring in numerator bits; the rest shift in zeros.
        always_comb
        begin
            if (k == 0)
            begin
                bx = lx_prev[1];
                by = ly_prev[1];
            end
            else if (k == 1)
            begin
                bx = lx_prev[0];
                by = ly_prev[0];
            end
            else
            begin
                bx = 1'b0;
                by = 1'b0;
            end
            tx = {rx_prev, bx};
            ty = {ry_prev, by};
            dx = {1'b0, tx} - {2'b00, d_prev};
            dy = {1'b0, ty} - {2'b00, d_prev};
            rx_next = dx[ppt_pkg::MAG_W+1] ? tx[ppt_pkg::MAG_W-1:0] : dx[ppt_pkg::MAG_W-1:0];
            ry_next = dy[ppt_pkg::MAG_W+1] ? ty[ppt_pkg::MAG_W-1:0] : dy[ppt_pkg::MAG_W-1:0];
            qx_next = {qx_prev[ppt_pkg::COORD_W-2:0], ~dx[ppt_pkg::MAG_W+1]};
            qy_next = {qy_prev[ppt_pkg::COORD_W-2:0], ~dy[ppt_pkg::MAG_W+1]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k]    <= d_prev;
                rx_reg[k]   <= rx_next;
                ry_reg[k]   <= ry_next;
                lx_reg[k]   <= lx_prev;
                ly_reg[k]   <= ly_prev;
                qx_reg[k]   <= qx_next;
                qy_reg[k]   <= qy_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign vld      = v_reg[N-1];
    assign qx       = qx_reg[N-1];
    assign qy       = qy_reg[N-1];
    assign side_out = side_reg[N-1];

endmodule

// ===== rtl/core/projective_point_transform.sv =====
// Top level of the projective point transform: configuration, pipeline and output register.
//
// Maps each (in_x, in_y) point through a 3x3 homography and delivers one word per
// point in order. A new point is accepted every cycle while the pipeline is not held;
// each passes from acceptance to a valid output through the products and row sums,
// the magnitudes and range checks, the one-bit-per-stage divider and the output
// register. The whole pipeline holds while an output word is stalled.
// cfg_ready is always high; registers should only be written while no points are
// in flight.
module projective_point_transform
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [ppt_pkg::COORD_W-1:0]   in_x,
    input  logic signed [ppt_pkg::COORD_W-1:0]   in_y,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [ppt_pkg::COORD_W-1:0]   out_x,
    output logic signed [ppt_pkg::COORD_W-1:0]   out_y,
    output logic [1:0]                           status,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ppt_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic [63:0]                       row0_xy_reg, row0_t_row1_x_reg, row1_y_t_reg, row2_xy_reg;
    logic [31:0]                       row2_t_reg;
    logic [ppt_pkg::MIN_DIV_W-1:0]     min_div_reg;
    ppt_pkg::coef_t                    coef;
    logic                              adv;

    logic                              rows_vld;
    logic signed [ppt_pkg::SUM_W-1:0]  w_sum, nx_sum, ny_sum;
    logic                              prep_vld;
    logic [ppt_pkg::MAG_W-1:0]         d_mag, rx_init, ry_init;
    logic [1:0]                        lx_bits, ly_bits;
    ppt_pkg::side_t                    prep_side, div_side;
    logic                              div_vld;
    logic [ppt_pkg::COORD_W-1:0]       qx, qy;

    logic                              out_valid_reg;
    logic signed [ppt_pkg::COORD_W-1:0] out_x_reg, out_y_reg, out_x_next, out_y_next;
    ppt_pkg::status_t                  status_reg, status_next;
    logic                              range_x, range_y;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_xy_reg       <= 64'h0001_0000_0000_0000;
            row0_t_row1_x_reg <= '0;
            row1_y_t_reg      <= 64'h0001_0000_0000_0000;
            row2_xy_reg       <= '0;
            row2_t_reg        <= 32'h0001_0000;
            min_div_reg       <= 31'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ppt_pkg::CFG_ROW0_XY:       row0_xy_reg       <= cfg_data;
                ppt_pkg::CFG_ROW0_T_ROW1_X: row0_t_row1_x_reg <= cfg_data;
                ppt_pkg::CFG_ROW1_Y_T:      row1_y_t_reg      <= cfg_data;
                ppt_pkg::CFG_ROW2_XY:       row2_xy_reg       <= cfg_data;
                ppt_pkg::CFG_ROW2_T:        row2_t_reg        <= cfg_data[31:0];
                ppt_pkg::CFG_MIN_DIV:       min_div_reg       <= cfg_data[ppt_pkg::MIN_DIV_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        coef.h00 = row0_xy_reg[63:32];
        coef.h01 = row0_xy_reg[31:0];
        coef.h02 = row0_t_row1_x_reg[63:32];
        coef.h10 = row0_t_row1_x_reg[31:0];
        coef.h11 = row1_y_t_reg[63:32];
        coef.h12 = row1_y_t_reg[31:0];
        coef.h20 = row2_xy_reg[63:32];
        coef.h21 = row2_xy_reg[31:0];
        coef.h22 = row2_t_reg;
    end

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    ppt_rows u_rows
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .in_vld (in_valid),
        .x      (in_x),
        .y      (in_y),
        .coef   (coef),
        .vld    (rows_vld),
        .w      (w_sum),
        .nx     (nx_sum),
        .ny     (ny_sum)
    );

    ppt_prep u_prep
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (rows_vld),
        .w       (w_sum),
        .nx      (nx_sum),
        .ny      (ny_sum),
        .min_div (min_div_reg),
        .vld     (prep_vld),
        .d       (d_mag),
        .rx      (rx_init),
        .ry      (ry_init),
        .lx      (lx_bits),
        .ly      (ly_bits),
        .side    (prep_side)
    );

    ppt_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (prep_vld),
        .d        (d_mag),
        .rx       (rx_init),
        .ry       (ry_init),
        .lx       (lx_bits),
        .ly       (ly_bits),
        .side_in  (prep_side),
        .vld      (div_vld),
        .qx       (qx),
        .qy       (qy),
        .side_out (div_side)
    );

    // A negative result may reach -2^31, a positive one only 2^31-1.
    always_comb
    begin
        range_x = div_side.neg_x ? (qx[31] && (qx[30:0] != '0)) : qx[31];
        range_y = div_side.neg_y ? (qy[31] && (qy[30:0] != '0)) : qy[31];
        out_x_next = '0;
        out_y_next = '0;
        if (div_side.div_err)
        begin
            status_next = ppt_pkg::STATUS_DIV;
        end
        else if (div_side.ovf_x || div_side.ovf_y || range_x || range_y)
        begin
            status_next = ppt_pkg::STATUS_RANGE;
        end
        else
        begin
            status_next = ppt_pkg::STATUS_OK;
            out_x_next  = div_side.neg_x ? -qx : qx;
            out_y_next  = div_side.neg_y ? -qy : qy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_x_reg  <= out_x_next;
            out_y_reg  <= out_y_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign status    = status_reg;

endmodule

// ===== dv/tb_projective_point_transform.sv =====
// Self-checking testbench for the projective point transform, with random idling on both sides.
`timescale 1ns / 1ps

module tb_projective_point_transform;

    // Expected result of one point.
    typedef struct {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        ppt_pkg::status_t   st;
    } mapped_pt_t;

    // Holds a copy of the matrix and the queue of mapped points still to arrive.
    class homography_sb;
        logic [63:0] row0_xy, row0_t_row1_x, row1_y_t, row2_xy;
        logic [31:0] row2_t;
        logic [30:0] min_div;
        mapped_pt_t  pending_q[$];
        int          errors;

        function void reset_regs();
            row0_xy       = 64'h0001_0000_0000_0000;
            row0_t_row1_x = '0;
            row1_y_t      = 64'h0001_0000_0000_0000;
            row2_xy       = '0;
            row2_t        = 32'h0001_0000;
            min_div       = 31'd1;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] val);
            case (idx)
                ppt_pkg::CFG_ROW0_XY:       row0_xy = val;
                ppt_pkg::CFG_ROW0_T_ROW1_X: row0_t_row1_x = val;
                ppt_pkg::CFG_ROW1_Y_T:      row1_y_t = val;
                ppt_pkg::CFG_ROW2_XY:       row2_xy = val;
                ppt_pkg::CFG_ROW2_T:        row2_t = val[31:0];
                ppt_pkg::CFG_MIN_DIV:       min_div = val[30:0];
                default: ;
            endcase
        endfunction

        // Numerator divided by w, scaled to Q16.16; returns 0 when out of range.
        function bit divide_q16(logic signed [95:0] num, logic [95:0] wmag, bit wneg,
                                output logic [31:0] q32);
            logic [127:0] nmag;
            logic [127:0] q;
            bit           neg;
            nmag = num < 0 ? 128'(-num) : 128'(num);
            neg  = (num < 0) != wneg;
            q    = (nmag << 30) / 128'(wmag);
            q32  = neg ? 32'(-q) : q[31:0];
            return q <= (neg ? 128'h8000_0000 : 128'h7FFF_FFFF);
        endfunction

        function void note_point(logic signed [31:0] x, logic signed [31:0] y);
            logic signed [95:0] xs, ys, wsum, nx, ny;
            logic [95:0]        wmag;
            logic [31:0]        qx, qy;
            mapped_pt_t         e;
            xs = x;
            ys = y;
            wsum = 96'(signed'(row2_xy[63:32])) * xs + 96'(signed'(row2_xy[31:0])) * ys
                 + (96'(signed'(row2_t)) <<< 30);
            nx = 96'(signed'(row0_xy[63:32])) * xs + 96'(signed'(row0_xy[31:0])) * ys
               + (96'(signed'(row0_t_row1_x[63:32])) <<< 16);
            ny = 96'(signed'(row0_t_row1_x[31:0])) * xs + 96'(signed'(row1_y_t[63:32])) * ys
               + (96'(signed'(row1_y_t[31:0])) <<< 16);
            wmag = wsum < 0 ? -wsum : wsum;
            e.ox = '0;
            e.oy = '0;
            // A zero divisor is an error even when the minimum is zero.
            if (wmag == 0 || wmag < (96'(min_div) << 30))
                e.st = ppt_pkg::STATUS_DIV;
            else if (!divide_q16(nx, wmag, wsum < 0, qx) || !divide_q16(ny, wmag, wsum < 0, qy))
                e.st = ppt_pkg::STATUS_RANGE;
            else begin
                e.st = ppt_pkg::STATUS_OK;
                e.ox = qx;
                e.oy = qy;
            end
            pending_q.insert(pending_q.size(), e);
        endfunction

        function void report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endfunction

        function void check_point(logic signed [31:0] ox, logic signed [31:0] oy,
                                  logic [1:0] st);
            mapped_pt_t e;
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word x=%h y=%h st=%0d", ox, oy, st));
                return;
            end
            e = pending_q.pop_front();
            if (st != e.st)
                report_mismatch($sformatf("status %0d, want %0d", st, e.st));
            if (ox != e.ox)
                report_mismatch($sformatf("out_x %h, want %h", ox, e.ox));
            if (oy != e.oy)
                report_mismatch($sformatf("out_y %h, want %h", oy, e.oy));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic        out_valid;
    logic        out_stall;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [1:0]  status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    homography_sb sb;
    int  cycles = 0;
    int  stall_pct;
    int  hold_cycles;
    bit  hold_req;

    projective_point_transform DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_x(in_x), .in_y(in_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_x(out_x), .out_y(out_y), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_point(out_x, out_y, status);
    end

    // Receiver: stall runs of random length, plus an occasional long hold.
    initial
    begin : receiver
        int run;
        bit stalled;
        run = 0;
        stalled = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                hold_cycles = 0;
                while (hold_cycles < 300)
                begin
                    @(negedge clk);
                    hold_cycles++;
                end
                hold_req = 1'b0;
            end
            if (run == 0)
            begin
                stalled = ($urandom_range(99) < stall_pct);
                run = $urandom_range(1, 8);
            end
            run--;
            out_stall <= stalled;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_point(logic signed [31:0] x, logic signed [31:0] y);
        @(negedge clk);
        in_valid <= 1'b1;
        in_x <= x;
        in_y <= y;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_point(x, y);
    endtask

    task automatic idle_sender(int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            in_x <= $urandom;
            in_y <= $urandom;
        end
    endtask

    // Stops offering points, waits until every word has come back, then lets the
    // pipeline settle.
    task automatic drain();
        idle_sender(1);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        idle_sender(50);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2 * 1024 * 65536)) - 1024 * 65536);
            2: return 32'($signed($urandom_range(0, 2 * 65536)) - 65536);
            default: return 32'($signed($urandom_range(0, 2 * 256 * 65536)) - 256 * 65536);
        endcase
    endfunction

    function automatic logic [31:0] rand_scale();
        logic [31:0] v;
        v = $urandom_range(16384, 262144);
        return $urandom_range(1) ? -v : v;
    endfunction

    function automatic logic [31:0] rand_small(int span);
        return 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic random_matrix(bit wild);
        if (wild)
        begin
            write_reg(ppt_pkg::CFG_ROW0_XY, {$urandom, $urandom});
            write_reg(ppt_pkg::CFG_ROW0_T_ROW1_X, {$urandom, $urandom});
            write_reg(ppt_pkg::CFG_ROW1_Y_T, {$urandom, $urandom});
            write_reg(ppt_pkg::CFG_ROW2_XY, {$urandom, $urandom});
            write_reg(ppt_pkg::CFG_ROW2_T, {32'h0, 32'($urandom)});
            write_reg(ppt_pkg::CFG_MIN_DIV, 64'($urandom_range(0, 4)));
        end
        else
        begin
            write_reg(ppt_pkg::CFG_ROW0_XY, {rand_scale(), rand_small(65536)});
            write_reg(ppt_pkg::CFG_ROW0_T_ROW1_X, {rand_small(1 << 26), rand_small(65536)});
            write_reg(ppt_pkg::CFG_ROW1_Y_T, {rand_scale(), rand_small(1 << 26)});
            write_reg(ppt_pkg::CFG_ROW2_XY, {rand_small(1 << 14), rand_small(1 << 14)});
            write_reg(ppt_pkg::CFG_ROW2_T, {32'h0, rand_scale()});
            write_reg(ppt_pkg::CFG_MIN_DIV, 64'($urandom_range(0, 4096)));
        end
    endtask

    task automatic random_points(int n, bit with_hold);
        int done;
        int burst;
        done = 0;
        while (done < n)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && done < n; i++)
            begin
                send_point(rand_coord(), rand_coord());
                done++;
                if (with_hold && done == 10)
                    hold_req = 1'b1;
            end
            if ($urandom_range(3) != 0)
                idle_sender($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        sb = new();
        sb.reset_regs();
        sb.errors = 0;
        stall_pct = 30;
        hold_req = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_x = '0;
        in_y = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Identity matrix: extremes of the coordinates pass straight through.
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_point(32'sh8000_0000, 32'sh8000_0000);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_point(32'sh0000_0000, 32'shFFFF_FFFF);
        send_point(32'sh0001_0000, -32'sh0001_0000);
        drain();

        // Divisor exactly zero with a zero minimum still flags the divisor.
        write_reg(ppt_pkg::CFG_ROW2_T, 64'h0);
        write_reg(ppt_pkg::CFG_MIN_DIV, 64'h0);
        send_point(32'sh0010_0000, 32'sh0020_0000);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
        drain();

        // Largest minimum, with the divisor set exactly to it: that divisor is not too small.
        write_reg(ppt_pkg::CFG_ROW2_T, 64'h7FFF_FFFF);
        write_reg(ppt_pkg::CFG_MIN_DIV, 64'h7FFF_FFFF);
        send_point(32'sh1234_5678, 32'sh8765_4321);
        send_point(32'sh0, 32'sh0);
        drain();
        write_reg(ppt_pkg::CFG_MIN_DIV, 64'h1);

        // Large gains overflow the output range; small inputs still map.
        write_reg(ppt_pkg::CFG_ROW2_T, 64'h0001_0000);
        write_reg(ppt_pkg::CFG_ROW0_XY, 64'h7FFF_FFFF_0000_0000);
        write_reg(ppt_pkg::CFG_ROW1_Y_T, 64'h8000_0000_0000_0000);
        send_point(32'sh7FFF_FFFF, 32'sh0);
        send_point(32'sh0, 32'sh8000_0000);
        send_point(32'sh0000_0001, 32'sh0000_0001);
        send_point(32'sh0000_8000, -32'sh0000_8000);
        drain();

        // All-ones and most-negative coefficients.
        write_reg(ppt_pkg::CFG_ROW0_XY, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(ppt_pkg::CFG_ROW0_T_ROW1_X, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(ppt_pkg::CFG_ROW1_Y_T, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(ppt_pkg::CFG_ROW2_XY, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(ppt_pkg::CFG_ROW2_T, 64'hFFFF_FFFF);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_point(32'sh8000_0000, 32'sh0000_0001);
        drain();
        write_reg(ppt_pkg::CFG_ROW2_XY, 64'h8000_0000_8000_0000);
        write_reg(ppt_pkg::CFG_ROW2_T, 64'h8000_0000);
        send_point(32'sh8000_0000, 32'sh8000_0000);
        send_point(32'sh0000_0400, -32'sh0000_0300);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            stall_pct = (phase == 2) ? 0 : $urandom_range(10, 60);
            random_matrix(phase == 4);
            random_points(85, phase == 1 || phase == 3);
            drain();
        end

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ppt_pkg.sv
rtl/core/ppt_rows.sv
rtl/core/ppt_prep.sv
rtl/core/ppt_div.sv
rtl/core/projective_point_transform.sv
dv/tb_projective_point_transform.sv
